FILE: src/sbb_pkg.sv
// Shared types and constants of the separable box blur.
`default_nettype none

package sbb_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned HSUM_W    = 13;
  localparam int unsigned FILT_W    = 5;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned AREA_W    = 2 * FILT_W;

  localparam logic [FILT_W-1:0] RST_FILTER = FILT_W'(3);
  localparam int unsigned       RST_IMG_W  = 640;
  localparam int unsigned       RST_IMG_H  = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_W = 4'd0,
    REG_FILTER_H = 4'd1,
    REG_IMAGE_W  = 4'd2,
    REG_IMAGE_H  = 4'd3
  } cfg_reg_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PIX  = 8'b0000_0010,
    ST_TAIL = 8'b0000_0100,
    ST_CHK  = 8'b0000_1000,
    ST_VRD  = 8'b0001_0000,
    ST_VACC = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: src/sbb_if.sv
// Handshake interfaces of the pixel input, the result output and the register port.
`default_nettype none

interface sbb_pix_if import sbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface sbb_out_if import sbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred;
  logic             frame_last;
  modport source (output valid, output blurred, output frame_last, input ready);
  modport sink   (input valid, input blurred, input frame_last, output ready);
endinterface

interface sbb_cfg_if import sbb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sbb_row_win.sv
// Circular window of the most recent pixels of the current input row.
`default_nettype none

module sbb_row_win import sbb_pkg::*; #(
  parameter int unsigned DEPTH  = 31,
  parameter int unsigned SLOT_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [PIX_W-1:0]  rdata_o
);

  logic [PIX_W-1:0] win_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) win_q[i] <= '0;
    end else if (we_i) begin
      win_q[waddr_i] <= wdata_i;
    end
  end

  // The read sees the old entry when it is overwritten in the same cycle.
  assign rdata_o = win_q[raddr_i];

endmodule

`default_nettype wire

FILE: src/sbb_line_mem.sv
// Line memory of horizontal sums, one write port and one registered read port.
`default_nettype none

module sbb_line_mem import sbb_pkg::*; #(
  parameter int unsigned DEPTH  = 31744,
  parameter int unsigned ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [HSUM_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [HSUM_W-1:0] rdata_o
);

  logic [HSUM_W-1:0] mem [DEPTH];
  logic [HSUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/sbb_div.sv
// Bit-serial restoring divider for the window sum over the window area.
`default_nettype none

module sbb_div import sbb_pkg::*; #(
  parameter int unsigned N = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [N-1:0]      dividend_i,
  input  logic [AREA_W-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [PIX_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [AREA_W-1:0] rem_q;
  logic [AREA_W-1:0] dvs_q;
  logic [N-1:0]      quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [AREA_W:0]   trial;
  logic              ge;

  assign trial = {rem_q, quo_q[N-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
        cnt_q  <= CNT_W'(N);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? AREA_W'(trial - {1'b0, dvs_q}) : trial[AREA_W-1:0];
        quo_q <= {quo_q[N-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The mean of 8-bit pixels always fits the low byte of the quotient.
  assign quot_o      = quo_q[PIX_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

FILE: src/separable_box_blur.sv
// Top level of the streaming separable box blur with edge replication.
//
//   port    dir  word                        accepted when
//   cfg_i   in   index, data                 valid && ready (ready while idle)
//   pix_i   in   action, pixel_in            valid && ready
//   blur_o  out  blurred, frame_last         valid && ready
//
// A word is accepted, then takes one row step, plus rh more steps after the last
// pixel of a row, then fh line-memory reads and one bit-serial division when it
// releases a result. The line memory has one read port, so its fh reads are serial.
// Reset clears all counters; the line memory is not cleared and needs no pass.
// A finished result waits in the output register while the next word is taken.
`default_nettype none

module separable_box_blur import sbb_pkg::*; #(
  parameter int unsigned MAX_FILTER = 31,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbb_pix_if.sink   pix_i,
  sbb_out_if.source blur_o,
  sbb_cfg_if.sink   cfg_i
);

  localparam int unsigned SLOT_W = $clog2(MAX_FILTER);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH  = MAX_FILTER * MAX_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned AW     = PIX_W + $clog2(MAX_FILTER + 1);
  localparam int unsigned VS_W   = HSUM_W + $clog2(MAX_FILTER + 1);
  localparam int unsigned SI_W   = COL_W + 2;
  localparam int unsigned RS_W   = ROW_W + 2;
  localparam int unsigned TW     = ((SLOT_W > FILT_W) ? SLOT_W : FILT_W) + 2;
  localparam int unsigned FTOP_R = (MAX_FILTER - 1) | 1;
  localparam int unsigned FTOP   = (FTOP_R > MAX_FILTER) ? FTOP_R - 2 : FTOP_R;
  localparam int unsigned RH_W   = FILT_W - 1;

  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                   input logic [FILT_W-1:0] a);
    logic [TW-1:0] t;
    t = TW'(s) + TW'(MAX_FILTER) - TW'(a);
    if (t >= TW'(MAX_FILTER)) t = t - TW'(MAX_FILTER);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(MAX_FILTER - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [FILT_W-1:0] odd_filter(input logic [SIZE_W-1:0] v);
    logic [FILT_W-1:0] f;
    f = v[FILT_W-1:0] | FILT_W'(1);
    return (f > FILT_W'(FTOP)) ? FILT_W'(FTOP) : f;
  endfunction

  // Configuration
  logic [FILT_W-1:0] fw_q, fh_q;
  logic [WD_W-1:0]   wd_q;
  logic [HT_W-1:0]   ht_q;
  logic [RH_W-1:0]   rh, rv;
  logic [SIZE_W-1:0] size_raw;
  logic [WD_W-1:0]   wd_new;
  logic [HT_W-1:0]   ht_new;
  logic              cfg_hit;

  // Control and positions
  state_e              state_q;
  logic [COL_W-1:0]    in_col_q, out_col_q;
  logic [ROW_W-1:0]    in_row_q, out_row_q;
  logic [SLOT_W-1:0]   in_slot_q, out_slot_q, wp_q;
  logic                in_done_q;
  logic [PIX_W-1:0]    pin_q, p0_q, plast_q;
  logic [AW-1:0]       acc_q;
  logic [RH_W-1:0]     tcnt_q;
  logic signed [SI_W-1:0] tidx_q, tcol_q;
  logic [SLOT_W-1:0]   tslot_q, trow_slot_q;
  logic signed [RS_W-1:0] u_q;
  logic [SLOT_W-1:0]   cslot_q;
  logic [FILT_W-1:0]   kcnt_q;
  logic                rdv_q;
  logic [VS_W-1:0]     vacc_q;
  logic                ov_q;
  logic [PIX_W-1:0]    oblur_q;
  logic                olast_q;

  // Datapath
  logic                   pix_acc;
  logic signed [SI_W-1:0] ri;
  logic [SLOT_W-1:0]      rs;
  logic [PIX_W-1:0]       win_rdata, old_pix, old_tail;
  logic [AW-1:0]          a_pix, a_tail;
  logic                   last_col, last_row;
  logic                   pix_store, tail_store;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [HSUM_W-1:0]      mem_wdata, mem_rdata;
  logic                   mem_we;
  logic [SLOT_W-1:0]      win_raddr;
  logic [HT_W:0]          rr_raw, rr, ht_m1;
  logic [WD_W:0]          cc_raw, cc, wd_m1;
  logic                   out_rdy;
  logic [RH_W-1:0]        dback;
  logic [RS_W-1:0]        u_nx;
  logic                   u_inc;
  logic                   div_start;
  logic [VS_W-1:0]        div_dvd;
  div_stat_t              div_stat;
  logic [PIX_W-1:0]       div_quot;
  logic                   out_load, out_last;

  assign rh = fw_q[FILT_W-1:1];
  assign rv = fh_q[FILT_W-1:1];

  assign pix_i.ready = (state_q == ST_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign cfg_hit     = cfg_i.valid && cfg_i.ready && (cfg_i.index == REG_FILTER_W ||
                       cfg_i.index == REG_FILTER_H || cfg_i.index == REG_IMAGE_W ||
                       cfg_i.index == REG_IMAGE_H);

  assign size_raw = (cfg_i.data == '0) ? SIZE_W'(1) : cfg_i.data;
  assign wd_new   = (32'(size_raw) > MAX_WIDTH) ? WD_W'(MAX_WIDTH) : WD_W'(size_raw);
  assign ht_new   = (32'(size_raw) > MAX_HEIGHT) ? HT_W'(MAX_HEIGHT) : HT_W'(size_raw);

  // Row step: the running sum drops the pixel that leaves the window and adds
  // the new one; indexes left of the row take the first pixel of the row.
  assign ri       = $signed(SI_W'(in_col_q)) - $signed(SI_W'(fw_q));
  assign rs       = slot_back(wp_q, fw_q);
  assign win_raddr = (state_q == ST_TAIL) ? tslot_q : rs;
  assign old_pix  = ri[SI_W-1] ? p0_q : win_rdata;
  assign old_tail = tidx_q[SI_W-1] ? p0_q : win_rdata;
  assign a_pix    = (in_col_q == '0) ? AW'(fw_q * pin_q)
                                     : acc_q + AW'(pin_q) - AW'(old_pix);
  assign a_tail   = acc_q + AW'(plast_q) - AW'(old_tail);
  assign last_col = (WD_W'(in_col_q) + WD_W'(1)) >= wd_q;
  assign last_row = (HT_W'(in_row_q) + HT_W'(1)) >= ht_q;

  assign pix_store  = (state_q == ST_PIX) && (in_col_q >= COL_W'(rh));
  assign tail_store = (state_q == ST_TAIL) && !tcol_q[SI_W-1];
  assign mem_we     = pix_store || tail_store;

  always_comb begin
    if (state_q == ST_TAIL) begin
      mem_waddr = ADDR_W'(trow_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tcol_q[COL_W-1:0]);
      mem_wdata = HSUM_W'(a_tail);
    end else begin
      mem_waddr = ADDR_W'(in_slot_q) * ADDR_W'(MAX_WIDTH)
                + ADDR_W'(in_col_q - COL_W'(rh));
      mem_wdata = HSUM_W'(a_pix);
    end
  end

  assign mem_raddr = ADDR_W'(cslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col_q);

  // An output is ready once the bottom-right pixel of its clamped window is in.
  assign ht_m1   = (HT_W + 1)'(ht_q) - (HT_W + 1)'(1);
  assign rr_raw  = (HT_W + 1)'(out_row_q) + (HT_W + 1)'(rv);
  assign rr      = (rr_raw > ht_m1) ? ht_m1 : rr_raw;
  assign wd_m1   = (WD_W + 1)'(wd_q) - (WD_W + 1)'(1);
  assign cc_raw  = (WD_W + 1)'(out_col_q) + (WD_W + 1)'(rh);
  assign cc      = (cc_raw > wd_m1) ? wd_m1 : cc_raw;
  assign out_rdy = in_done_q || (rr < (HT_W + 1)'(in_row_q)) ||
                   ((rr == (HT_W + 1)'(in_row_q)) && (cc < (WD_W + 1)'(in_col_q)));

  // Vertical walk: rows above the top edge read row zero, rows below the
  // bottom edge keep reading the last row.
  assign dback = (out_row_q < ROW_W'(rv)) ? RH_W'(out_row_q) : rv;
  assign u_nx  = $unsigned(u_q) + RS_W'(1);
  assign u_inc = !u_q[RS_W-1] && (u_nx < RS_W'(ht_q));

  assign div_start = (state_q == ST_VACC);
  assign div_dvd   = vacc_q + VS_W'(mem_rdata);

  assign out_load = (state_q == ST_OUT) && (!ov_q || blur_o.ready);
  assign out_last = ((HT_W'(out_row_q) + HT_W'(1)) >= ht_q) &&
                    ((WD_W'(out_col_q) + WD_W'(1)) >= wd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= RST_FILTER;
      fh_q        <= RST_FILTER;
      wd_q        <= WD_W'(RST_IMG_W);
      ht_q        <= HT_W'(RST_IMG_H);
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      in_done_q   <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      wp_q        <= '0;
      pin_q       <= '0;
      p0_q        <= '0;
      plast_q     <= '0;
      acc_q       <= '0;
      tcnt_q      <= '0;
      tidx_q      <= '0;
      tcol_q      <= '0;
      tslot_q     <= '0;
      trow_slot_q <= '0;
      u_q         <= '0;
      cslot_q     <= '0;
      kcnt_q      <= '0;
      rdv_q       <= 1'b0;
      vacc_q      <= '0;
      ov_q        <= 1'b0;
      oblur_q     <= '0;
      olast_q     <= 1'b0;
    end else begin
      if (ov_q && blur_o.ready && !out_load) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (pix_acc) begin
            pin_q   <= pix_i.pixel_in;
            state_q <= (!pix_i.action && !in_done_q) ? ST_PIX : ST_CHK;
          end
        end
        ST_PIX: begin
          acc_q       <= a_pix;
          plast_q     <= pin_q;
          if (in_col_q == '0) p0_q <= pin_q;
          tidx_q      <= ri + SI_W'(1);
          tslot_q     <= slot_inc(rs);
          tcol_q      <= $signed(SI_W'(in_col_q)) - $signed(SI_W'(rh)) + SI_W'(1);
          trow_slot_q <= in_slot_q;
          tcnt_q      <= rh;
          if (last_col) begin
            in_col_q <= '0;
            wp_q     <= '0;
            if (last_row) begin
              in_row_q  <= '0;
              in_slot_q <= '0;
              in_done_q <= 1'b1;
            end else begin
              in_row_q  <= in_row_q + ROW_W'(1);
              in_slot_q <= slot_inc(in_slot_q);
            end
          end else begin
            in_col_q <= in_col_q + COL_W'(1);
            wp_q     <= slot_inc(wp_q);
          end
          state_q <= (last_col && rh != '0) ? ST_TAIL : ST_CHK;
        end
        ST_TAIL: begin
          acc_q   <= a_tail;
          tidx_q  <= tidx_q + SI_W'(1);
          tslot_q <= slot_inc(tslot_q);
          tcol_q  <= tcol_q + SI_W'(1);
          tcnt_q  <= tcnt_q - RH_W'(1);
          if (tcnt_q == RH_W'(1)) state_q <= ST_CHK;
        end
        ST_CHK: begin
          u_q     <= $signed(RS_W'(out_row_q)) - $signed(RS_W'(rv));
          cslot_q <= slot_back(out_slot_q, FILT_W'(dback));
          kcnt_q  <= fh_q;
          rdv_q   <= 1'b0;
          vacc_q  <= '0;
          state_q <= out_rdy ? ST_VRD : ST_IDLE;
        end
        ST_VRD: begin
          rdv_q <= 1'b1;
          if (rdv_q) vacc_q <= vacc_q + VS_W'(mem_rdata);
          u_q <= u_q + RS_W'(1);
          if (u_inc) cslot_q <= slot_inc(cslot_q);
          kcnt_q <= kcnt_q - FILT_W'(1);
          if (kcnt_q == FILT_W'(1)) state_q <= ST_VACC;
        end
        ST_VACC: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            ov_q    <= 1'b1;
            oblur_q <= div_quot;
            olast_q <= out_last;
            if (out_last) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_slot_q  <= '0;
              in_done_q  <= 1'b0;
              wp_q       <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_slot_q <= '0;
            end else if ((WD_W'(out_col_q) + WD_W'(1)) >= wd_q) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + ROW_W'(1);
              out_slot_q <= slot_inc(out_slot_q);
            end else begin
              out_col_q <= out_col_q + COL_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Register writes arrive only while idle and restart the frame.
      if (cfg_hit) begin
        case (cfg_i.index)
          REG_FILTER_W: fw_q <= odd_filter(cfg_i.data);
          REG_FILTER_H: fh_q <= odd_filter(cfg_i.data);
          REG_IMAGE_W:  wd_q <= wd_new;
          REG_IMAGE_H:  ht_q <= ht_new;
          default: ;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        in_done_q  <= 1'b0;
        wp_q       <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
      end
    end
  end

  assign blur_o.valid      = ov_q;
  assign blur_o.blurred    = oblur_q;
  assign blur_o.frame_last = olast_q;

  sbb_row_win #(
    .DEPTH  (MAX_FILTER),
    .SLOT_W (SLOT_W)
  ) u_row_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (state_q == ST_PIX),
    .waddr_i (wp_q),
    .wdata_i (pin_q),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  sbb_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_VRD),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sbb_div #(
    .N (VS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (AREA_W'(fw_q * fh_q)),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

endmodule

`default_nettype wire

FILE: src/sbb_checker.sv
// Port-level checks of the box blur, bound to the top level.
`default_nettype none

module sbb_checker import sbb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_blurred_i,
  input logic             out_last_i
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_blurred_i) &&
    $stable(out_last_i))
    else $error("result word changed while stalled");

  // The block works on one word at a time, so it is busy after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again in the next cycle");

  // A new result is loaded only by the engine, never from the idle state.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the engine was idle");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (blur_o.valid),
  .out_ready_i   (blur_o.ready),
  .out_blurred_i (blur_o.blurred),
  .out_last_i    (blur_o.frame_last)
);

`default_nettype wire
